/* sv/rpe_pkg.sv */
// shared types and constants of the reactivity profile engine
package rpe_pkg;

  // default sizing
  localparam int MAX_LEN_DEF     = 255;
  localparam int COUNT_WIDTH_DEF = 32;

  // fixed point constants
  localparam int          NL_W     = 29;
  localparam int          FR_BITS  = 28;
  localparam logic [30:0] ONE_Q30  = 31'h4000_0000;
  localparam logic [29:0] LN2_Q30  = 30'd744261118;
  localparam logic [31:0] SAT32    = 32'hFFFF_FFFF;
  localparam logic [7:0]  TL_RESET = 8'd255;

  // opcodes
  localparam logic [1:0] OP_FRAG    = 2'd0;
  localparam logic [1:0] OP_COMPUTE = 2'd1;
  localparam logic [1:0] OP_READ    = 2'd2;

  // main sequencer states
  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FRAG,
    ST_READ,
    ST_NOP,
    ST_P1_RD,
    ST_P1_CHK,
    ST_P1_DIVP,
    ST_P1_DIVM,
    ST_P1_BETA,
    ST_P2_RD,
    ST_P2_CHK,
    ST_P2_LN,
    ST_P3_RD,
    ST_P3_CHK,
    ST_P3_DIVP,
    ST_P3_LNP,
    ST_P3_DIVM,
    ST_P3_LNM,
    ST_P3_THETA,
    ST_DONE
  } rpe_state_t;

  // log unit phases
  typedef enum logic [2:0] {
    LN_IDLE,
    LN_NORM,
    LN_SQR,
    LN_MUL,
    LN_RND
  } rpe_ln_phase_t;

endpackage

/* sv/reactivity_profile_engine_core.sv */
// reactivity profile engine: histograms, profile compute and readout
//
// usage: an item is taken at a clock edge with start high and busy low.
// opcode 0 counts a fragment in the treated or untreated histogram,
// opcode 1 computes betas, c and thetas over positions 0..N, opcode 2
// reads one position of every store. every item gives exactly one result,
// shown for one cycle with out_strobe high; the receiver cannot stall.
// fragment, read and unused opcodes: out_strobe rises at the first edge
// after the accepting edge, and the next item can be taken in the strobe
// cycle.
// compute walks the profile three times through the memories; each position
// costs up to three divisions in pass one, at most one log in pass two, and
// up to three divisions plus two logs in pass three. the shared restoring
// divider and the squaring log unit carry them all out.
// configuration: cfg_ready is always high; target_length is written when
// cfg_valid is high; the user writes only while idle, unchecked by the block.
// reset: a clearing pass writes zero to every entry of the four memories
// with busy high; afterwards target_length is 255 and scale c is zero.
module reactivity_profile_engine_core #(
  parameter int MAX_LEN     = rpe_pkg::MAX_LEN_DEF,
  parameter int COUNT_WIDTH = rpe_pkg::COUNT_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  logic [1:0]             in_opcode,
  input  logic                   in_is_treated,
  input  logic signed [15:0]     in_frag_left,
  input  logic signed [15:0]     in_frag_right,
  input  logic [7:0]             in_read_index,
  output logic                   out_strobe,
  output logic                   out_kept,
  output logic                   out_status,
  output logic [31:0]            out_c_value,
  output logic [30:0]            out_beta_value,
  output logic [31:0]            out_theta_value,
  output logic [COUNT_WIDTH-1:0] out_treated_count,
  output logic [COUNT_WIDTH-1:0] out_untreated_count,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [7:0]             cfg_data
);
  import rpe_pkg::*;

  localparam int DEPTH  = MAX_LEN + 1;
  localparam int AW     = $clog2(DEPTH);
  localparam int KW     = AW + 1;
  localparam int LW     = (KW > 8) ? KW : 8;
  localparam int SUM_W  = COUNT_WIDTH + AW;
  localparam int ACC_W  = AW + 30;
  localparam int NUM_W  = (COUNT_WIDTH > 30) ? COUNT_WIDTH + 30 : 60;
  localparam int DEN_W  = AW + ((COUNT_WIDTH > 30) ? COUNT_WIDTH : 30);
  localparam int DCW    = $clog2(NUM_W + 1);

  // memories
  logic [COUNT_WIDTH-1:0] hist_t_mem [DEPTH];
  logic [COUNT_WIDTH-1:0] hist_u_mem [DEPTH];
  logic [30:0]            beta_mem   [DEPTH];
  logic [31:0]            theta_mem  [DEPTH];
  logic [COUNT_WIDTH-1:0] ht_q, hu_q;
  logic [30:0]            beta_q;
  logic [31:0]            theta_q;
  logic [AW-1:0]          rd_addr, wr_addr;
  logic                   ht_we, hu_we, beta_we, theta_we;
  logic [COUNT_WIDTH-1:0] ht_wdata, hu_wdata;
  logic [30:0]            beta_wdata;
  logic [31:0]            theta_wdata;

  // sequencer state
  rpe_state_t             state_r, state_nxt;
  logic [KW-1:0]          k_r, k_nxt;
  logic [SUM_W-1:0]       sp_r, sp_nxt, sm_r, sm_nxt;
  logic [COUNT_WIDTH-1:0] t_r, t_nxt, u_r, u_nxt;
  logic [30:0]            p_r, p_nxt, m_r, m_nxt;
  logic [NL_W-1:0]        lp_r, lp_nxt;
  logic [ACC_W-1:0]       acc_r, acc_nxt;
  logic [31:0]            scale_c_r, scale_c_nxt;
  logic                   issued_r, issued_nxt;
  logic                   keep_r, keep_nxt, chan_r, chan_nxt, idx_ok_r, idx_ok_nxt;
  logic [AW-1:0]          widx_r, widx_nxt;
  logic [7:0]             target_length_r;

  // result registers
  logic                   out_strobe_r, out_strobe_nxt;
  logic                   out_kept_r, out_kept_nxt, out_status_r, out_status_nxt;
  logic [31:0]            out_c_r, out_c_nxt;
  logic [30:0]            out_beta_r, out_beta_nxt;
  logic [31:0]            out_theta_r, out_theta_nxt;
  logic [COUNT_WIDTH-1:0] out_tc_r, out_tc_nxt, out_uc_r, out_uc_nxt;

  // divider
  logic                   div_go;
  logic [NUM_W-1:0]       div_num;
  logic [DEN_W-1:0]       div_den;
  logic                   div_busy_r, div_busy_nxt;
  logic [DCW-1:0]         div_cnt_r, div_cnt_nxt;
  logic [DEN_W-1:0]       div_rem_r, div_rem_nxt, div_den_r, div_den_nxt;
  logic [NUM_W-1:0]       div_quo_r, div_quo_nxt;
  logic [DEN_W:0]         div_trial;
  logic                   div_ge;

  // log unit
  logic                   ln_go;
  logic [30:0]            ln_q;
  rpe_ln_phase_t          ln_phase_r, ln_phase_nxt;
  logic [31:0]            ln_y_r, ln_y_nxt;
  logic [4:0]             ln_e_r, ln_e_nxt, ln_cnt_r, ln_cnt_nxt;
  logic [FR_BITS-1:0]     ln_fr_r, ln_fr_nxt;
  logic [62:0]            ln_prod_r, ln_prod_nxt;
  logic [NL_W-1:0]        ln_res_r, ln_res_nxt;
  logic [61:0]            ln_sq;
  logic [32:0]            ln_l2;
  logic [62:0]            ln_rnd;
  logic                   ln_busy;

  // shared conditions
  logic                   accept;
  logic [KW-1:0]          n_len;
  logic [LW-1:0]          tl_ext;
  logic                   frag_keep, read_ok;
  logic [SUM_W-1:0]       sum_p, sum_m;
  logic                   sum_zero, k_last, div_done, ln_done;
  logic                   beta_zero, theta_zero, theta_sat;
  logic [NL_W-1:0]        theta_x;
  logic [31:0]            acc_sat;

  // port handshakes
  assign busy       = (state_r != ST_IDLE);
  assign accept     = start && !busy;
  assign cfg_ready  = 1'b1;

  // effective length and input checks
  assign tl_ext    = LW'(target_length_r);
  assign n_len     = (tl_ext > LW'(MAX_LEN)) ? KW'(MAX_LEN) : KW'(tl_ext);
  assign frag_keep = !in_frag_left[15] && ($unsigned(in_frag_left) <= 16'(n_len)) &&
                     ($unsigned(in_frag_right) == 16'(n_len));
  assign read_ok   = (LW'(in_read_index) <= LW'(MAX_LEN));

  // walk conditions
  assign sum_p      = sp_r + SUM_W'(ht_q);
  assign sum_m      = sm_r + SUM_W'(hu_q);
  assign sum_zero   = (sum_p == '0) || (sum_m == '0);
  assign k_last     = (k_r == n_len);
  assign div_done   = issued_r && !div_busy_r;
  assign ln_done    = issued_r && !ln_busy;
  assign beta_zero  = (SUM_W'(u_r) == sm_r) || (p_r <= m_r);
  assign theta_x    = lp_r - ln_res_r;
  assign theta_zero = (acc_r == '0) || (lp_r <= ln_res_r);
  assign theta_sat  = ((ACC_W + 8)'(theta_x) >= {acc_r, 8'h00});
  assign acc_sat    = (acc_r > ACC_W'(SAT32)) ? SAT32 : acc_r[31:0];

  // memory addresses
  always_comb begin
    if (state_r == ST_IDLE) begin
      rd_addr = (in_opcode == OP_FRAG) ? in_frag_left[AW-1:0] : AW'(in_read_index);
    end else begin
      rd_addr = k_r[AW-1:0];
    end
    wr_addr = (state_r == ST_FRAG) ? widx_r : k_r[AW-1:0];
  end

  // memories with registered read
  always_ff @(posedge clk) begin
    if (ht_we) hist_t_mem[wr_addr] <= ht_wdata;
    if (hu_we) hist_u_mem[wr_addr] <= hu_wdata;
    if (beta_we) beta_mem[wr_addr] <= beta_wdata;
    if (theta_we) theta_mem[wr_addr] <= theta_wdata;
    ht_q    <= hist_t_mem[rd_addr];
    hu_q    <= hist_u_mem[rd_addr];
    beta_q  <= beta_mem[rd_addr];
    theta_q <= theta_mem[rd_addr];
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (k_r == KW'(DEPTH - 1)) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          case (in_opcode)
            OP_FRAG:    state_nxt = ST_FRAG;
            OP_COMPUTE: state_nxt = ST_P1_RD;
            OP_READ:    state_nxt = ST_READ;
            default:    state_nxt = ST_NOP;
          endcase
        end
      end
      ST_FRAG, ST_READ, ST_NOP, ST_DONE: state_nxt = ST_IDLE;
      ST_P1_RD: state_nxt = ST_P1_CHK;
      ST_P1_CHK: begin
        if (!sum_zero) state_nxt = ST_P1_DIVP;
        else if (k_last) state_nxt = ST_P2_RD;
        else state_nxt = ST_P1_RD;
      end
      ST_P1_DIVP: if (div_done) state_nxt = ST_P1_DIVM;
      ST_P1_DIVM: if (div_done) state_nxt = ST_P1_BETA;
      ST_P1_BETA: begin
        if (beta_zero || div_done) state_nxt = k_last ? ST_P2_RD : ST_P1_RD;
      end
      ST_P2_RD: state_nxt = (k_r > n_len) ? ST_P3_RD : ST_P2_CHK;
      ST_P2_CHK: begin
        if (beta_q[30]) state_nxt = ST_IDLE;
        else if (beta_q != '0) state_nxt = ST_P2_LN;
        else if (k_last) state_nxt = ST_P3_RD;
        else state_nxt = ST_P2_RD;
      end
      ST_P2_LN: if (ln_done) state_nxt = k_last ? ST_P3_RD : ST_P2_RD;
      ST_P3_RD: state_nxt = ST_P3_CHK;
      ST_P3_CHK: begin
        if (k_r != '0 && !sum_zero) state_nxt = ST_P3_DIVP;
        else if (k_last) state_nxt = ST_DONE;
        else state_nxt = ST_P3_RD;
      end
      ST_P3_DIVP: if (div_done) state_nxt = ST_P3_LNP;
      ST_P3_LNP:  if (ln_done) state_nxt = ST_P3_DIVM;
      ST_P3_DIVM: if (div_done) state_nxt = ST_P3_LNM;
      ST_P3_LNM:  if (ln_done) state_nxt = ST_P3_THETA;
      ST_P3_THETA: begin
        if (theta_zero || theta_sat || div_done) state_nxt = k_last ? ST_DONE : ST_P3_RD;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath and results
  always_comb begin
    k_nxt          = k_r;
    sp_nxt         = sp_r;
    sm_nxt         = sm_r;
    t_nxt          = t_r;
    u_nxt          = u_r;
    p_nxt          = p_r;
    m_nxt          = m_r;
    lp_nxt         = lp_r;
    acc_nxt        = acc_r;
    scale_c_nxt    = scale_c_r;
    issued_nxt     = issued_r;
    keep_nxt       = keep_r;
    chan_nxt       = chan_r;
    idx_ok_nxt     = idx_ok_r;
    widx_nxt       = widx_r;
    ht_we          = 1'b0;
    hu_we          = 1'b0;
    beta_we        = 1'b0;
    theta_we       = 1'b0;
    ht_wdata       = '0;
    hu_wdata       = '0;
    beta_wdata     = '0;
    theta_wdata    = '0;
    div_go         = 1'b0;
    div_num        = NUM_W'(t_r) << 30;
    div_den        = DEN_W'(sp_r);
    ln_go          = 1'b0;
    ln_q           = ONE_Q30 - p_r;
    out_strobe_nxt = 1'b0;
    out_kept_nxt   = 1'b0;
    out_status_nxt = 1'b0;
    out_c_nxt      = '0;
    out_beta_nxt   = '0;
    out_theta_nxt  = '0;
    out_tc_nxt     = '0;
    out_uc_nxt     = '0;
    case (state_r)
      ST_CLEAR: begin
        ht_we    = 1'b1;
        hu_we    = 1'b1;
        beta_we  = 1'b1;
        theta_we = 1'b1;
        k_nxt    = k_r + 1'b1;
      end
      ST_IDLE: begin
        keep_nxt   = frag_keep;
        chan_nxt   = in_is_treated;
        widx_nxt   = in_frag_left[AW-1:0];
        idx_ok_nxt = read_ok;
        k_nxt      = '0;
        sp_nxt     = '0;
        sm_nxt     = '0;
        acc_nxt    = '0;
        issued_nxt = 1'b0;
      end
      // saturating count update
      ST_FRAG: begin
        ht_wdata       = (ht_q == '1) ? ht_q : ht_q + 1'b1;
        hu_wdata       = (hu_q == '1) ? hu_q : hu_q + 1'b1;
        ht_we          = keep_r && chan_r;
        hu_we          = keep_r && !chan_r;
        out_strobe_nxt = 1'b1;
        out_kept_nxt   = keep_r;
      end
      ST_READ: begin
        out_strobe_nxt = 1'b1;
        out_c_nxt      = scale_c_r;
        if (idx_ok_r) begin
          out_beta_nxt  = beta_q;
          out_theta_nxt = theta_q;
          out_tc_nxt    = ht_q;
          out_uc_nxt    = hu_q;
        end
      end
      ST_NOP: out_strobe_nxt = 1'b1;
      // pass one: betas
      ST_P1_CHK: begin
        sp_nxt = sum_p;
        sm_nxt = sum_m;
        t_nxt  = ht_q;
        u_nxt  = hu_q;
        if (sum_zero) k_nxt = k_last ? KW'(1) : k_r + 1'b1;
      end
      ST_P1_DIVP: begin
        div_num = NUM_W'(t_r) << 30;
        div_den = DEN_W'(sp_r);
        if (!issued_r) begin
          div_go     = 1'b1;
          issued_nxt = 1'b1;
        end else if (div_done) begin
          p_nxt      = div_quo_r[30:0];
          issued_nxt = 1'b0;
        end
      end
      ST_P1_DIVM: begin
        div_num = NUM_W'(u_r) << 30;
        div_den = DEN_W'(sm_r);
        if (!issued_r) begin
          div_go     = 1'b1;
          issued_nxt = 1'b1;
        end else if (div_done) begin
          m_nxt      = div_quo_r[30:0];
          issued_nxt = 1'b0;
        end
      end
      ST_P1_BETA: begin
        div_num = NUM_W'(p_r - m_r) << 30;
        div_den = DEN_W'(ONE_Q30 - m_r);
        if (beta_zero) begin
          beta_we = 1'b1;
          k_nxt   = k_last ? KW'(1) : k_r + 1'b1;
        end else if (!issued_r) begin
          div_go     = 1'b1;
          issued_nxt = 1'b1;
        end else if (div_done) begin
          beta_we    = 1'b1;
          beta_wdata = div_quo_r[30:0];
          issued_nxt = 1'b0;
          k_nxt      = k_last ? KW'(1) : k_r + 1'b1;
        end
      end
      // pass two: sum of logs into c
      ST_P2_RD: begin
        if (k_r > n_len) begin
          k_nxt  = '0;
          sp_nxt = '0;
          sm_nxt = '0;
        end
      end
      ST_P2_CHK: begin
        p_nxt = beta_q;
        if (beta_q[30]) begin
          out_strobe_nxt = 1'b1;
          out_status_nxt = 1'b1;
          out_c_nxt      = scale_c_r;
        end else if (beta_q == '0) begin
          k_nxt = k_last ? '0 : k_r + 1'b1;
          if (k_last) begin
            sp_nxt = '0;
            sm_nxt = '0;
          end
        end
      end
      ST_P2_LN: begin
        ln_q = ONE_Q30 - p_r;
        if (!issued_r) begin
          ln_go      = 1'b1;
          issued_nxt = 1'b1;
        end else if (ln_done) begin
          acc_nxt    = acc_r + ACC_W'(ln_res_r);
          issued_nxt = 1'b0;
          k_nxt      = k_last ? '0 : k_r + 1'b1;
          if (k_last) begin
            sp_nxt = '0;
            sm_nxt = '0;
          end
        end
      end
      // pass three: thetas
      ST_P3_CHK: begin
        sp_nxt = sum_p;
        sm_nxt = sum_m;
        t_nxt  = ht_q;
        u_nxt  = hu_q;
        if (k_r == '0 || sum_zero) k_nxt = k_r + 1'b1;
      end
      ST_P3_DIVP: begin
        div_num = NUM_W'(t_r) << 30;
        div_den = DEN_W'(sp_r);
        if (!issued_r) begin
          div_go     = 1'b1;
          issued_nxt = 1'b1;
        end else if (div_done) begin
          p_nxt      = div_quo_r[30:0];
          issued_nxt = 1'b0;
        end
      end
      ST_P3_LNP: begin
        ln_q = ONE_Q30 - p_r;
        if (!issued_r) begin
          ln_go      = 1'b1;
          issued_nxt = 1'b1;
        end else if (ln_done) begin
          lp_nxt     = ln_res_r;
          issued_nxt = 1'b0;
        end
      end
      ST_P3_DIVM: begin
        div_num = NUM_W'(u_r) << 30;
        div_den = DEN_W'(sm_r);
        if (!issued_r) begin
          div_go     = 1'b1;
          issued_nxt = 1'b1;
        end else if (div_done) begin
          m_nxt      = div_quo_r[30:0];
          issued_nxt = 1'b0;
        end
      end
      ST_P3_LNM: begin
        ln_q = ONE_Q30 - m_r;
        if (!issued_r) begin
          ln_go      = 1'b1;
          issued_nxt = 1'b1;
        end else if (ln_done) begin
          issued_nxt = 1'b0;
        end
      end
      ST_P3_THETA: begin
        div_num = NUM_W'(theta_x) << 24;
        div_den = DEN_W'(acc_r);
        if (theta_zero) begin
          theta_we = 1'b1;
          k_nxt    = k_r + 1'b1;
        end else if (theta_sat) begin
          theta_we    = 1'b1;
          theta_wdata = SAT32;
          k_nxt       = k_r + 1'b1;
        end else if (!issued_r) begin
          div_go     = 1'b1;
          issued_nxt = 1'b1;
        end else if (div_done) begin
          theta_we    = 1'b1;
          theta_wdata = div_quo_r[31:0];
          issued_nxt  = 1'b0;
          k_nxt       = k_r + 1'b1;
        end
      end
      ST_DONE: begin
        scale_c_nxt    = acc_sat;
        out_strobe_nxt = 1'b1;
        out_c_nxt      = acc_sat;
      end
      default: begin
      end
    endcase
  end

  // restoring divider step, one quotient bit a cycle
  assign div_trial = {div_rem_r, div_quo_r[NUM_W-1]};
  assign div_ge    = (div_trial >= {1'b0, div_den_r});

  always_comb begin
    div_busy_nxt = div_busy_r;
    div_cnt_nxt  = div_cnt_r;
    div_rem_nxt  = div_rem_r;
    div_quo_nxt  = div_quo_r;
    div_den_nxt  = div_den_r;
    if (div_go) begin
      div_busy_nxt = 1'b1;
      div_cnt_nxt  = '0;
      div_rem_nxt  = '0;
      div_quo_nxt  = div_num;
      div_den_nxt  = div_den;
    end else if (div_busy_r) begin
      div_rem_nxt = div_ge ? DEN_W'(div_trial - {1'b0, div_den_r}) : DEN_W'(div_trial);
      div_quo_nxt = {div_quo_r[NUM_W-2:0], div_ge};
      div_cnt_nxt = div_cnt_r + 1'b1;
      if (div_cnt_r == DCW'(NUM_W - 1)) div_busy_nxt = 1'b0;
    end
  end

  // log unit: normalize, square for log2 bits, scale by ln2 and round
  assign ln_busy = (ln_phase_r != LN_IDLE);
  assign ln_sq   = 62'(ln_y_r[30:0]) * 62'(ln_y_r[30:0]);
  assign ln_l2   = {ln_e_r, 28'h0} - 33'(ln_fr_r);
  assign ln_rnd  = ln_prod_r + (63'd1 << 33);

  always_comb begin
    ln_phase_nxt = ln_phase_r;
    ln_y_nxt     = ln_y_r;
    ln_e_nxt     = ln_e_r;
    ln_cnt_nxt   = ln_cnt_r;
    ln_fr_nxt    = ln_fr_r;
    ln_prod_nxt  = ln_prod_r;
    ln_res_nxt   = ln_res_r;
    case (ln_phase_r)
      LN_IDLE: begin
        if (ln_go) begin
          ln_y_nxt     = (ln_q == '0) ? 32'd1 : 32'(ln_q);
          ln_e_nxt     = '0;
          ln_phase_nxt = LN_NORM;
        end
      end
      LN_NORM: begin
        if (ln_y_r < 32'(ONE_Q30)) begin
          ln_y_nxt = ln_y_r << 1;
          ln_e_nxt = ln_e_r + 1'b1;
        end else begin
          ln_cnt_nxt   = '0;
          ln_fr_nxt    = '0;
          ln_phase_nxt = LN_SQR;
        end
      end
      LN_SQR: begin
        if (ln_sq[61]) begin
          ln_y_nxt  = {1'b0, ln_sq[61:31]};
          ln_fr_nxt = {ln_fr_r[FR_BITS-2:0], 1'b1};
        end else begin
          ln_y_nxt  = ln_sq[61:30];
          ln_fr_nxt = {ln_fr_r[FR_BITS-2:0], 1'b0};
        end
        ln_cnt_nxt = ln_cnt_r + 1'b1;
        if (ln_cnt_r == 5'(FR_BITS - 1)) ln_phase_nxt = LN_MUL;
      end
      LN_MUL: begin
        ln_prod_nxt  = 63'(ln_l2) * 63'(LN2_Q30);
        ln_phase_nxt = LN_RND;
      end
      LN_RND: begin
        ln_res_nxt   = ln_rnd[34+NL_W-1:34];
        ln_phase_nxt = LN_IDLE;
      end
      default: ln_phase_nxt = LN_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= ST_CLEAR;
      k_r             <= '0;
      issued_r        <= 1'b0;
      scale_c_r       <= '0;
      target_length_r <= TL_RESET;
      out_strobe_r    <= 1'b0;
      div_busy_r      <= 1'b0;
      ln_phase_r      <= LN_IDLE;
    end else begin
      state_r      <= state_nxt;
      k_r          <= k_nxt;
      issued_r     <= issued_nxt;
      scale_c_r    <= scale_c_nxt;
      out_strobe_r <= out_strobe_nxt;
      div_busy_r   <= div_busy_nxt;
      ln_phase_r   <= ln_phase_nxt;
      if (cfg_valid && cfg_ready) target_length_r <= cfg_data;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    sp_r         <= sp_nxt;
    sm_r         <= sm_nxt;
    t_r          <= t_nxt;
    u_r          <= u_nxt;
    p_r          <= p_nxt;
    m_r          <= m_nxt;
    lp_r         <= lp_nxt;
    acc_r        <= acc_nxt;
    keep_r       <= keep_nxt;
    chan_r       <= chan_nxt;
    idx_ok_r     <= idx_ok_nxt;
    widx_r       <= widx_nxt;
    out_kept_r   <= out_kept_nxt;
    out_status_r <= out_status_nxt;
    out_c_r      <= out_c_nxt;
    out_beta_r   <= out_beta_nxt;
    out_theta_r  <= out_theta_nxt;
    out_tc_r     <= out_tc_nxt;
    out_uc_r     <= out_uc_nxt;
    div_cnt_r    <= div_cnt_nxt;
    div_rem_r    <= div_rem_nxt;
    div_quo_r    <= div_quo_nxt;
    div_den_r    <= div_den_nxt;
    ln_y_r       <= ln_y_nxt;
    ln_e_r       <= ln_e_nxt;
    ln_cnt_r     <= ln_cnt_nxt;
    ln_fr_r      <= ln_fr_nxt;
    ln_prod_r    <= ln_prod_nxt;
    ln_res_r     <= ln_res_nxt;
  end

  // result ports
  assign out_strobe          = out_strobe_r;
  assign out_kept            = out_kept_r;
  assign out_status          = out_status_r;
  assign out_c_value         = out_c_r;
  assign out_beta_value      = out_beta_r;
  assign out_theta_value     = out_theta_r;
  assign out_treated_count   = out_tc_r;
  assign out_untreated_count = out_uc_r;

endmodule
